[design/stl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types and codes of the script token lexer: result words, the
// per-character bundle passed from the front end to the back end.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int unsigned LineW  = 24;
  localparam int unsigned LenW   = 7;
  localparam int unsigned SlotN  = 3;
  localparam int unsigned CntW   = 2;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;

  // result kinds
  localparam logic [1:0] KindChar = 2'd0;
  localparam logic [1:0] KindEnd  = 2'd1;
  localparam logic [1:0] KindErr  = 2'd2;
  localparam logic [1:0] KindEos  = 2'd3;

  // token kinds
  localparam logic [2:0] TokNum = 3'd0;
  localparam logic [2:0] TokStr = 3'd1;
  localparam logic [2:0] TokVar = 3'd2;
  localparam logic [2:0] TokCmd = 3'd3;
  localparam logic [2:0] TokSym = 3'd4;

  // error codes
  localparam logic [1:0] ErrNone     = 2'd0;
  localparam logic [1:0] ErrInvalid  = 2'd1;
  localparam logic [1:0] ErrUnclosed = 2'd2;
  localparam logic [1:0] ErrTooLong  = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] tok;
    logic [7:0] ch;
    logic [1:0] err;
  } res_t;

  // all results of one input character, in order; they share one line number
  typedef struct packed {
    logic [CntW-1:0]  cnt;
    logic [LineW-1:0] line;
    res_t [SlotN-1:0] res;
  } bundle_t;

endpackage
`default_nettype wire

[design/script_token_lexer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// script_token_lexer
// Character-stream lexer: one character word in, token character, token end,
// error and stream end words out.
// ----------------------------------------------------------------------------
// The front end takes one character word per cycle and turns it into a
// bundle of zero to three result words in the same cycle; words with no
// result (whitespace, comment text) leave nothing behind. Bundles wait in a
// four-entry queue, and the back end sends one result word per cycle from
// the head bundle unless out_stall_i is high, and the sustained rate is one
// character per cycle while each produces at most one result and out_stall_i
// stays low. in_stall_o rises only when the queue is full.
// All result words of one character carry the same line number.
// ----------------------------------------------------------------------------
module script_token_lexer #(
  parameter int unsigned MAX_TOKEN_CHARS = 79
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_char_i,
  input  wire logic        end_of_input_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [2:0]       token_kind_o,
  output logic [7:0]       char_value_o,
  output logic [23:0]      line_number_o,
  output logic [1:0]       error_code_o,
  output logic             last_o
);
  import stl_pkg::*;

  bundle_t bundle, head;
  logic    take, push, pop, full, empty;

  assign in_stall_o = full;
  assign take       = in_valid_i && !full;
  assign push       = take && (bundle.cnt != '0);

  stl_front #(
    .MaxTokenChars (MAX_TOKEN_CHARS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .in_char_i      (in_char_i),
    .end_of_input_i (end_of_input_i),
    .bundle_o       (bundle)
  );

  stl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (bundle),
    .pop_i   (pop),
    .rdata_o (head),
    .full_o  (full),
    .empty_o (empty)
  );

  stl_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .token_kind_o  (token_kind_o),
    .char_value_o  (char_value_o),
    .line_number_o (line_number_o),
    .error_code_o  (error_code_o),
    .last_o        (last_o)
  );

endmodule
`default_nettype wire

[design/stl_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stl_front
// Classifies each input character, tracks lexer mode, comments, line count
// and token length, and builds the bundle of results it causes.
// ----------------------------------------------------------------------------
module stl_front #(
  parameter int unsigned MaxTokenChars = 79
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             take_i,
  input  wire logic [7:0]       in_char_i,
  input  wire logic             end_of_input_i,
  output stl_pkg::bundle_t      bundle_o
);
  import stl_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE, M_INT, M_FRAC, M_STR, M_VAR, M_CMD
  } mode_e;

  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [LenW-1:0] MaxLen = LenW'(MaxTokenChars);

  mode_e            mode_q, mode_d;
  logic [LineW-1:0] line_q, line_d;
  logic [LenW-1:0]  len_q, len_d;
  logic             ovf_q, ovf_d;
  logic             cmt_q, cmt_d;

  logic             eof;
  logic [7:0]       c;
  logic             is_digit, is_letter, is_space, is_sym, is_sign;
  logic             go, do_idle, em_req, post_req;
  logic [2:0]       em_tok, tk_vc;
  res_t             post_res;
  logic [CntW-1:0]  n;
  res_t [SlotN-1:0] slot;

  function automatic res_t mk(logic [1:0] kind, logic [2:0] tok, logic [7:0] ch,
                              logic [1:0] err);
    res_t r;
    r.kind = kind;
    r.tok  = tok;
    r.ch   = ch;
    r.err  = err;
    return r;
  endfunction

  assign eof       = end_of_input_i;
  assign c         = eof ? 8'h00 : in_char_i;
  assign is_digit  = (c >= "0") && (c <= "9");
  assign is_letter = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z")) || (c == "_");
  assign is_space  = (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChCr);
  assign is_sym    = (c == "{") || (c == "}") || (c == "(") || (c == ")") || (c == ",");
  assign is_sign   = (c == "+") || (c == "-");

  always_comb begin
    mode_d   = mode_q;
    line_d   = line_q;
    len_d    = len_q;
    ovf_d    = ovf_q;
    cmt_d    = cmt_q;
    go       = 1'b1;
    do_idle  = 1'b0;
    em_req   = 1'b0;
    em_tok   = TokNum;
    post_req = 1'b0;
    post_res = mk(KindEos, TokNum, 8'h00, ErrNone);
    n        = '0;
    slot     = '0;
    tk_vc    = (mode_q == M_VAR) ? TokVar : TokCmd;

    // comment removal and line counting come before everything else
    if (cmt_q) begin
      if (eof) begin
        if (line_d != '1) line_d = line_d + 1'b1;
        cmt_d = 1'b0;
      end else begin
        if (c == ChLf) begin
          if (line_d != '1) line_d = line_d + 1'b1;
          cmt_d = 1'b0;
        end
        go = 1'b0;
      end
    end else if (!eof) begin
      if (c == ChSemi) begin
        cmt_d = 1'b1;
        go    = 1'b0;
      end else if (c == ChLf) begin
        if (line_d != '1) line_d = line_d + 1'b1;
      end
    end

    if (go) begin
      unique case (mode_q)
        M_INT, M_FRAC: begin
          if (!eof && is_digit) begin
            em_req = 1'b1;
            em_tok = TokNum;
          end else if (!eof && (c == ChDot) && (mode_q == M_INT)) begin
            em_req = 1'b1;
            em_tok = TokNum;
            mode_d = M_FRAC;
          end else begin
            slot[n] = mk(KindEnd, TokNum, 8'h00, ErrNone);
            n       = n + 1'b1;
            do_idle = 1'b1;
          end
        end
        M_STR: begin
          if (eof || (c == ChLf) || (c == ChCr)) begin
            slot[n] = mk(KindErr, TokStr, 8'h00, ErrUnclosed);
            n       = n + 1'b1;
            mode_d  = M_IDLE;
            do_idle = eof;
          end else if (c == ChQuote) begin
            slot[n] = mk(KindEnd, TokStr, 8'h00, ErrNone);
            n       = n + 1'b1;
            mode_d  = M_IDLE;
          end else begin
            em_req = 1'b1;
            em_tok = TokStr;
          end
        end
        M_VAR, M_CMD: begin
          if (!eof && is_letter) begin
            em_req = 1'b1;
            em_tok = tk_vc;
          end else begin
            slot[n] = mk(KindEnd, tk_vc, 8'h00, ErrNone);
            n       = n + 1'b1;
            do_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      // character seen between tokens
      if (do_idle) begin
        mode_d = M_IDLE;
        if (eof) begin
          post_req = 1'b1;
          post_res = mk(KindEos, TokNum, 8'h00, ErrNone);
        end else if (is_space) begin
          mode_d = M_IDLE;
        end else if (is_sym) begin
          len_d    = '0;
          ovf_d    = 1'b0;
          em_req   = 1'b1;
          em_tok   = TokSym;
          post_req = 1'b1;
          post_res = mk(KindEnd, TokSym, 8'h00, ErrNone);
        end else if (c == ChPct) begin
          len_d  = '0;
          ovf_d  = 1'b0;
          mode_d = M_VAR;
        end else if (is_digit || is_sign) begin
          len_d  = '0;
          ovf_d  = 1'b0;
          mode_d = M_INT;
          em_req = 1'b1;
          em_tok = TokNum;
        end else if (c == ChQuote) begin
          len_d  = '0;
          ovf_d  = 1'b0;
          mode_d = M_STR;
        end else if (is_letter) begin
          len_d  = '0;
          ovf_d  = 1'b0;
          mode_d = M_CMD;
          em_req = 1'b1;
          em_tok = TokCmd;
        end else begin
          post_req = 1'b1;
          post_res = mk(KindErr, TokNum, c, ErrInvalid);
        end
      end

      // token character, or a single overflow error once the limit is hit
      if (em_req) begin
        if (len_d < MaxLen) begin
          slot[n] = mk(KindChar, em_tok, c, ErrNone);
          n       = n + 1'b1;
          len_d   = len_d + 1'b1;
        end else if (!ovf_d) begin
          ovf_d   = 1'b1;
          slot[n] = mk(KindErr, em_tok, 8'h00, ErrTooLong);
          n       = n + 1'b1;
        end
      end

      if (post_req) begin
        slot[n] = post_res;
        n       = n + 1'b1;
      end
    end
  end

  assign bundle_o.cnt  = n;
  assign bundle_o.line = line_d;
  assign bundle_o.res  = slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      line_q <= LineW'(1);
      len_q  <= '0;
      ovf_q  <= 1'b0;
      cmt_q  <= 1'b0;
    end else if (take_i) begin
      mode_q <= mode_d;
      line_q <= line_d;
      len_q  <= len_d;
      ovf_q  <= ovf_d;
      cmt_q  <= cmt_d;
    end
  end

endmodule
`default_nettype wire

[design/stl_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stl_queue
// Short bundle queue between the front end and the back end.
// ----------------------------------------------------------------------------
module stl_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire stl_pkg::bundle_t wdata_i,
  input  wire logic             pop_i,
  output stl_pkg::bundle_t      rdata_o,
  output logic                  full_o,
  output logic                  empty_o
);
  import stl_pkg::*;

  bundle_t          mem_q [QDepth];
  logic [QPtrW:0]   wr_q, wr_d, rd_q, rd_d;

  assign full_o  = (wr_q[QPtrW] != rd_q[QPtrW]) && (wr_q[QPtrW-1:0] == rd_q[QPtrW-1:0]);
  assign empty_o = (wr_q == rd_q);
  assign rdata_o = mem_q[rd_q[QPtrW-1:0]];
  assign wr_d    = wr_q + (QPtrW+1)'(push_i);
  assign rd_d    = rd_q + (QPtrW+1)'(pop_i);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q[QPtrW-1:0]] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

endmodule
`default_nettype wire

[design/stl_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stl_back
// Walks the head bundle, one result word per unstalled cycle; marks the last.
// ----------------------------------------------------------------------------
module stl_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire stl_pkg::bundle_t head_i,
  input  wire logic             empty_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [1:0]            kind_o,
  output logic [2:0]            token_kind_o,
  output logic [7:0]            char_value_o,
  output logic [23:0]           line_number_o,
  output logic [1:0]            error_code_o,
  output logic                  last_o
);
  import stl_pkg::*;

  logic [CntW-1:0] idx_q, idx_d;
  logic            fire, at_last;
  res_t            cur;

  assign cur           = head_i.res[idx_q];
  assign at_last       = (idx_q == (head_i.cnt - 1'b1));
  assign out_valid_o   = !empty_i;
  assign fire          = out_valid_o && !out_stall_i;
  assign pop_o         = fire && at_last;
  assign idx_d         = pop_o ? '0 : (fire ? idx_q + 1'b1 : idx_q);

  assign kind_o        = cur.kind;
  assign token_kind_o  = cur.tok;
  assign char_value_o  = cur.ch;
  assign line_number_o = head_i.line;
  assign error_code_o  = cur.err;
  assign last_o        = at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the script token lexer. A short table of hand-picked
// characters comes first, then random token sequences mixed with noise,
// comments and end-of-text marks. Every accepted character word runs through
// a local lexer model, and each result word is checked against its prediction.
// ----------------------------------------------------------------------------
module tb;
  import stl_pkg::*;

  localparam int          MaxTok     = 79;
  localparam int          DirN       = 25;
  localparam int          RandItems  = 400;
  localparam int          WatchLimit = 1000;
  localparam int          TailCycles = 40;
  localparam logic [23:0] LineTop    = 24'hFFFFFF;

  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChQuote = 8'h22;

  typedef enum logic [2:0] {LxIdle, LxInt, LxFrac, LxStr, LxVar, LxCmd} lex_mode_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  tok;
    logic [7:0]  ch;
    logic [23:0] line;
    logic [1:0]  err;
    logic        last;
  } lex_word_t;

  typedef struct packed {
    logic [7:0] c;
    logic       eoi;
    logic       typed;
    lex_word_t  want;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] c;
    logic       eoi;
  } char_word_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic [7:0]  in_char_i      = 8'h00;
  logic        end_of_input_i = 1'b0;
  logic        out_stall_i    = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  kind_o;
  logic [2:0]  token_kind_o;
  logic [7:0]  char_value_o;
  logic [23:0] line_number_o;
  logic [1:0]  error_code_o;
  logic        last_o;

  // side band of the word on the input port: a typed-in expectation
  logic        in_typed = 1'b0;
  lex_word_t   in_want  = '0;

  logic [9:0]  cyc_cnt   = '0;
  int unsigned idle_cyc  = 0;
  int unsigned hold_left = 0;
  int unsigned err_cnt   = 0;
  wire         calm      = (cyc_cnt[9:8] == 2'b11);

  // model state
  lex_mode_e   lx_mode = LxIdle;
  logic [23:0] lx_line = 24'd1;
  logic [6:0]  lx_len  = '0;
  logic        lx_ovf  = 1'b0;
  logic        lx_cmt  = 1'b0;
  lex_word_t   lx_res [3];
  int          lx_n;

  lex_word_t   tok_words_due [$];
  char_word_t  char_stream [$];

  dir_row_t dir_tab [DirN] = '{
    '{8'h00,   1'b0, 1'b1, '{KindErr, TokNum, 8'h00, 24'd1, ErrInvalid, 1'b1}},
    '{8'hFF,   1'b0, 1'b1, '{KindErr, TokNum, 8'hFF, 24'd1, ErrInvalid, 1'b1}},
    '{8'hA5,   1'b1, 1'b1, '{KindEos, TokNum, 8'h00, 24'd1, ErrNone, 1'b1}},
    '{"{",     1'b0, 1'b0, '0},
    '{"%",     1'b0, 1'b0, '0},
    '{"a",     1'b0, 1'b0, '0},
    '{"1",     1'b0, 1'b0, '0},  // closes variable, starts number
    '{".",     1'b0, 1'b0, '0},
    '{"5",     1'b0, 1'b0, '0},
    '{ChQuote, 1'b0, 1'b0, '0},
    '{"x",     1'b0, 1'b0, '0},
    '{ChLf,    1'b0, 1'b0, '0},  // string cut by newline
    '{"-",     1'b0, 1'b0, '0},
    '{";",     1'b0, 1'b0, '0},  // comment inside a number
    '{"q",     1'b0, 1'b0, '0},
    '{ChLf,    1'b0, 1'b0, '0},
    '{"7",     1'b0, 1'b0, '0},
    '{8'h3C,   1'b1, 1'b0, '0},
    '{"%",     1'b0, 1'b0, '0},
    '{",",     1'b0, 1'b0, '0},  // empty variable, then a symbol: three words
    '{"Z",     1'b0, 1'b0, '0},
    '{ChCr,    1'b0, 1'b0, '0},
    '{ChQuote, 1'b0, 1'b0, '0},
    '{8'h00,   1'b1, 1'b0, '0},  // string cut by end of text
    '{"+",     1'b0, 1'b0, '0}
  };

  script_token_lexer #(
    .MAX_TOKEN_CHARS(MaxTok)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_char_i     (in_char_i),
    .end_of_input_i(end_of_input_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .token_kind_o  (token_kind_o),
    .char_value_o  (char_value_o),
    .line_number_o (line_number_o),
    .error_code_o  (error_code_o),
    .last_o        (last_o)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------- lexer model
  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic void lx_put(logic [1:0] k, logic [2:0] t, logic [7:0] c, logic [1:0] e);
    if (lx_n < 3) begin
      lx_res[lx_n] = '{kind: k, tok: t, ch: c, line: lx_line, err: e, last: 1'b0};
      lx_n++;
    end
  endfunction

  function automatic void bump_line();
    if (lx_line != LineTop) lx_line++;
  endfunction

  function automatic void lx_start(lex_mode_e m);
    lx_mode = m;
    lx_len  = '0;
    lx_ovf  = 1'b0;
  endfunction

  // past the length limit one error word, then the rest of the token is dropped
  function automatic void lx_emit(logic [2:0] t, logic [7:0] c);
    if (lx_len < MaxTok) begin
      lx_put(KindChar, t, c, ErrNone);
      lx_len++;
    end else if (!lx_ovf) begin
      lx_ovf = 1'b1;
      lx_put(KindErr, t, 8'h00, ErrTooLong);
    end
  endfunction

  function automatic void lx_close(logic [2:0] t);
    lx_put(KindEnd, t, 8'h00, ErrNone);
    lx_mode = LxIdle;
  endfunction

  function automatic void lex_idle(logic [7:0] c, logic eoi);
    lx_mode = LxIdle;
    if (eoi) begin
      lx_put(KindEos, TokNum, 8'h00, ErrNone);
    end else if (c == ChSp || c == ChTab || c == ChLf || c == ChCr) begin
      lx_n = lx_n;
    end else if (c == "{" || c == "}" || c == "(" || c == ")" || c == ",") begin
      lx_start(LxIdle);
      lx_emit(TokSym, c);
      lx_put(KindEnd, TokSym, 8'h00, ErrNone);
    end else if (c == "%") begin
      lx_start(LxVar);
    end else if (is_digit(c) || c == "+" || c == "-") begin
      lx_start(LxInt);
      lx_emit(TokNum, c);
    end else if (c == ChQuote) begin
      lx_start(LxStr);
    end else if (is_letter(c)) begin
      lx_start(LxCmd);
      lx_emit(TokCmd, c);
    end else begin
      lx_put(KindErr, TokNum, c, ErrInvalid);
    end
  endfunction

  function automatic void lex_char(logic [7:0] raw, logic eoi);
    logic [7:0] c;
    logic [2:0] tk;
    c = eoi ? 8'h00 : raw;
    lx_n = 0;
    if (lx_cmt) begin
      if (eoi) begin
        bump_line();
        lx_cmt = 1'b0;
      end else begin
        if (c == ChLf) begin
          bump_line();
          lx_cmt = 1'b0;
        end
        return;
      end
    end else if (!eoi) begin
      if (c == ";") begin
        lx_cmt = 1'b1;
        return;
      end
      if (c == ChLf) bump_line();
    end
    case (lx_mode)
      LxInt: begin
        if (!eoi && is_digit(c)) begin
          lx_emit(TokNum, c);
        end else if (!eoi && c == ".") begin
          lx_emit(TokNum, c);
          lx_mode = LxFrac;
        end else begin
          lx_close(TokNum);
          lex_idle(c, eoi);
        end
      end
      LxFrac: begin
        if (!eoi && is_digit(c)) begin
          lx_emit(TokNum, c);
        end else begin
          lx_close(TokNum);
          lex_idle(c, eoi);
        end
      end
      LxStr: begin
        if (eoi || c == ChLf || c == ChCr) begin
          lx_put(KindErr, TokStr, 8'h00, ErrUnclosed);
          lx_mode = LxIdle;
          if (eoi) lex_idle(c, eoi);
        end else if (c == ChQuote) begin
          lx_close(TokStr);
        end else begin
          lx_emit(TokStr, c);
        end
      end
      LxVar, LxCmd: begin
        tk = (lx_mode == LxVar) ? TokVar : TokCmd;
        if (!eoi && is_letter(c)) begin
          lx_emit(tk, c);
        end else begin
          lx_close(tk);
          lex_idle(c, eoi);
        end
      end
      default: begin
        lex_idle(c, eoi);
      end
    endcase
    if (lx_n > 0) lx_res[lx_n-1].last = 1'b1;
  endfunction

  // ------------------------------------------------------------ random stimulus
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] r;
    r = 8'($urandom_range(0, 52));
    if (r < 26) return 8'h41 + r;
    if (r < 52) return 8'h61 + r - 8'd26;
    return "_";
  endfunction

  function automatic logic [7:0] rand_digit();
    logic [7:0] r;
    r = 8'($urandom_range(0, 9));
    return 8'h30 + r;
  endfunction

  // printable text with no quote and no comment start
  function automatic logic [7:0] rand_text();
    logic [7:0] r;
    r = 8'($urandom_range(8'h20, 8'h7E));
    if (r == ChQuote || r == ";") r = "q";
    return r;
  endfunction

  task automatic put_stim(input logic [7:0] c, input logic e);
    char_stream.push_back('{c: c, eoi: e});
  endtask

  task automatic add_piece(input int idx);
    int unsigned r;
    int unsigned n;
    logic [7:0]  b;
    string       syms;
    string       blanks;
    string       broken;
    syms   = "{}(),";
    blanks = " \t\n\r";
    broken = ".\"%+-;";
    r = $urandom_range(0, 99);
    if (idx == 10 || idx == 60) begin
      // one token surely past the limit, one around it
      n = (idx == 10) ? MaxTok + 1 + $urandom_range(0, 5) : MaxTok - 1 + $urandom_range(0, 4);
      case ($urandom_range(0, 3))
        0: repeat (n) put_stim(rand_digit(), 1'b0);
        1: repeat (n) put_stim(rand_letter(), 1'b0);
        2: begin
          put_stim("%", 1'b0);
          repeat (n) put_stim(rand_letter(), 1'b0);
        end
        default: begin
          put_stim(ChQuote, 1'b0);
          repeat (n) put_stim(rand_text(), 1'b0);
          put_stim(ChQuote, 1'b0);
        end
      endcase
      put_stim(ChSp, 1'b0);
    end else if (r < 12) begin
      put_stim(syms[$urandom_range(0, 4)], 1'b0);
    end else if (r < 24) begin
      if ($urandom_range(0, 2) == 0) put_stim($urandom_range(0, 1) ? "+" : "-", 1'b0);
      repeat ($urandom_range(1, 4)) put_stim(rand_digit(), 1'b0);
      if ($urandom_range(0, 1) == 1) begin
        put_stim(".", 1'b0);
        repeat ($urandom_range(0, 3)) put_stim(rand_digit(), 1'b0);
      end
    end else if (r < 34) begin
      repeat ($urandom_range(1, 6)) put_stim(rand_letter(), 1'b0);
    end else if (r < 42) begin
      put_stim("%", 1'b0);
      repeat ($urandom_range(0, 5)) put_stim(rand_letter(), 1'b0);
    end else if (r < 52) begin
      put_stim(ChQuote, 1'b0);
      repeat ($urandom_range(0, 6)) put_stim(rand_text(), 1'b0);
      case ($urandom_range(0, 9))
        7:       put_stim(ChLf, 1'b0);
        8:       put_stim(ChCr, 1'b0);
        9:       put_stim(8'($urandom_range(0, 255)), 1'b1);
        default: put_stim(ChQuote, 1'b0);
      endcase
    end else if (r < 68) begin
      repeat ($urandom_range(1, 3)) put_stim(blanks[$urandom_range(0, 3)], 1'b0);
    end else if (r < 76) begin
      put_stim(";", 1'b0);
      repeat ($urandom_range(0, 5)) begin
        b = 8'($urandom_range(0, 255));
        put_stim((b == ChLf) ? 8'hFF : b, 1'b0);
      end
      if ($urandom_range(0, 3) == 0) put_stim(8'($urandom_range(0, 255)), 1'b1);
      else put_stim(ChLf, 1'b0);
    end else if (r < 86) begin
      put_stim(8'($urandom_range(0, 255)), 1'b0);
    end else if (r < 92) begin
      put_stim(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      put_stim(broken[$urandom_range(0, 5)], 1'b0);
    end
    if ($urandom_range(0, 1) == 1) put_stim(ChSp, 1'b0);
  endtask

  // ---------------------------------------------------------------- checking
  task automatic flag_mismatch(input string msg);
    err_cnt++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [23:0] got,
                             input logic [23:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin : check_words
    lex_word_t w;
    if (!rst_ni) begin
      lx_mode = LxIdle;
      lx_line = 24'd1;
      lx_len  = '0;
      lx_ovf  = 1'b0;
      lx_cmt  = 1'b0;
    end else begin
      // result words first: a character accepted at this edge cannot show yet
      if (out_valid_o && !out_stall_i) begin
        if (tok_words_due.size() == 0) begin
          flag_mismatch("result word with nothing expected");
        end else begin
          w = tok_words_due.pop_front();
          check_field("kind", 24'(kind_o), 24'(w.kind));
          check_field("token_kind", 24'(token_kind_o), 24'(w.tok));
          check_field("char_value", 24'(char_value_o), 24'(w.ch));
          check_field("line_number", line_number_o, w.line);
          check_field("error_code", 24'(error_code_o), 24'(w.err));
          check_field("last", 24'(last_o), 24'(w.last));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        lex_char(in_char_i, end_of_input_i);
        if (in_typed) begin
          tok_words_due.push_back(in_want);
        end else begin
          for (int k = 0; k < lx_n; k++) tok_words_due.push_back(lx_res[k]);
        end
      end
    end
  end

  // receiver stalls in random runs
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      if (hold_left == 0) out_stall_i <= 1'b0;
    end else begin
      hold_left = pick_gap();
      if (hold_left != 0) out_stall_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 10'd1;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cyc = 0;
    else idle_cyc++;
    if (idle_cyc == WatchLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // ------------------------------------------------------------------ driver
  task automatic send_word(input logic [7:0] c, input logic e, input logic typed,
                           input lex_word_t want);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_char_i      <= c;
    end_of_input_i <= e;
    in_typed       <= typed;
    in_want        <= want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  initial begin : main_seq
    char_word_t s;
    int         idx;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tab[i]) begin
      send_word(dir_tab[i].c, dir_tab[i].eoi, dir_tab[i].typed, dir_tab[i].want);
    end
    idx = 0;
    while (char_stream.size() < RandItems) begin
      add_piece(idx);
      idx++;
    end
    while (char_stream.size() != 0) begin
      s = char_stream.pop_front();
      send_word(s.c, s.eoi, 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    in_typed   <= 1'b0;
    @(posedge clk_i);
    while (tok_words_due.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (tok_words_due.size() != 0) flag_mismatch("expected words never arrived");
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
